// ===== src/bpc_pkg.sv =====
package bpc_pkg;

  // Configuration port geometry
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BUTTON_ENABLED = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_MS    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS_MS  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_GAP_MS  = 8'd3;

  // Reset values of the configuration registers
  localparam logic [15:0] DEBOUNCE_RST   = 16'd50;
  localparam logic [15:0] LONG_PRESS_RST = 16'd1000;
  localparam logic [15:0] DOUBLE_GAP_RST = 16'd300;

  // Press event codes
  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SHORT  = 2'd1,
    EV_LONG   = 2'd2,
    EV_DOUBLE = 2'd3
  } bpc_event_t;

  // Configuration registers as one group
  typedef struct packed {
    logic        button_enabled;
    logic [15:0] debounce_ms;
    logic [15:0] long_press_ms;
    logic [15:0] double_gap_ms;
  } bpc_cfg_t;

  // Press tracking state
  typedef struct packed {
    logic        was_pressed;
    logic        awaiting_second;
    logic [31:0] press_start_time;
    logic [31:0] release_time;
  } bpc_state_t;

endpackage

// ===== src/bpc_classify.sv =====
module bpc_classify (
  input  bpc_pkg::bpc_cfg_t   cfg,
  input  bpc_pkg::bpc_state_t st,
  input  logic [31:0]         now_ms,
  input  logic                pin_level,
  output bpc_pkg::bpc_state_t st_nxt,
  output bpc_pkg::bpc_event_t press_event
);
  import bpc_pkg::*;

  logic        down;
  logic [31:0] hold;
  logic [31:0] since_release;

  // Pin is active low; elapsed times wrap modulo 2^32
  assign down          = ~pin_level;
  assign hold          = now_ms - st.press_start_time;
  assign since_release = now_ms - st.release_time;

  // Edge detection and hold classification for one poll
  always_comb begin
    st_nxt      = st;
    press_event = EV_NONE;
    if (cfg.button_enabled) begin
      if (down && !st.was_pressed) begin
        // press edge: remember when it started
        st_nxt.was_pressed      = 1'b1;
        st_nxt.press_start_time = now_ms;
      end else if (!down && st.was_pressed) begin
        // release edge: classify the hold
        st_nxt.was_pressed = 1'b0;
        if (hold < {16'd0, cfg.debounce_ms}) begin
          press_event = EV_NONE;
        end else if (hold >= {16'd0, cfg.long_press_ms}) begin
          st_nxt.awaiting_second = 1'b0;
          press_event            = EV_LONG;
        end else if (st.awaiting_second) begin
          st_nxt.awaiting_second = 1'b0;
          press_event            = EV_DOUBLE;
        end else begin
          st_nxt.awaiting_second = 1'b1;
          st_nxt.release_time    = now_ms;
        end
      end else if (st.awaiting_second && !down &&
                   (since_release > {16'd0, cfg.double_gap_ms})) begin
        // no second press within the gap: report the single short press
        st_nxt.awaiting_second = 1'b0;
        press_event            = EV_SHORT;
      end
    end
  end

endmodule

// ===== src/button_press_classifier.sv =====
// Button press classifier. Each input item is one poll (millisecond timestamp
// and raw active-low pin level) and yields exactly one result item: none,
// short, long or double press. Throughput is one item per clock while out_stall
// does not hold the result register; an accepted poll passes through the input
// register and then the result register, around the combinational classify
// step that also updates the press state. in_stall rises only while the result
// register is held by out_stall and the input register is full. Configuration
// writes take effect on the next clock and should be made while no item is in
// flight.
module button_press_classifier (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [31:0]                      in_now_ms,
  input  logic                             in_pin_level,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       out_press_event,
  input  logic                             cfg_we,
  input  logic [bpc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bpc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import bpc_pkg::*;

  bpc_cfg_t   cfg_r;
  bpc_state_t state_r;
  bpc_state_t state_nxt;
  bpc_event_t event_nxt;
  logic       s1_valid_r;
  logic [31:0] s1_now_r;
  logic       s1_pin_r;
  logic       out_valid_r;
  bpc_event_t out_event_r;
  logic       advance;

  // Pipeline flow: stage 1 moves on when the result register is free
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !advance;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.button_enabled <= 1'b0;
      cfg_r.debounce_ms    <= DEBOUNCE_RST;
      cfg_r.long_press_ms  <= LONG_PRESS_RST;
      cfg_r.double_gap_ms  <= DOUBLE_GAP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BUTTON_ENABLED: cfg_r.button_enabled <= cfg_wdata[0];
        CFG_DEBOUNCE_MS:    cfg_r.debounce_ms    <= cfg_wdata;
        CFG_LONG_PRESS_MS:  cfg_r.long_press_ms  <= cfg_wdata;
        CFG_DOUBLE_GAP_MS:  cfg_r.double_gap_ms  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input register: valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  // Input register: payload
  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_now_r <= in_now_ms;
      s1_pin_r <= in_pin_level;
    end
  end

  // Classify the registered poll against the current state
  bpc_classify u_classify (
    .cfg         (cfg_r),
    .st          (state_r),
    .now_ms      (s1_now_r),
    .pin_level   (s1_pin_r),
    .st_nxt      (state_nxt),
    .press_event (event_nxt)
  );

  // Press state, updated once per item as it leaves stage 1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (s1_valid_r && advance) begin
      state_r <= state_nxt;
    end
  end

  // Result register: valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  // Result register: payload
  always_ff @(posedge clk) begin
    if (s1_valid_r && advance) begin
      out_event_r <= event_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_press_event = out_event_r;

endmodule

// ===== src/bpc_checker.sv =====
module bpc_assertions (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic [1:0] out_press_event
);

  // Reset empties the result side
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // A stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_press_event))
    else $error("stalled result changed");

  // Input back-pressure only comes from a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("in_stall without a stalled result");

  // An accepted item reaches the output once the result register is not blocked
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) ##1 (!out_valid || !out_stall) |=> out_valid)
    else $error("accepted item did not produce a result");

endmodule

bind button_press_classifier bpc_assertions u_bpc_assertions (.*);

// ===== tb/bpc_checker.sv =====
`timescale 1ns / 1ps

// Watches the poll, result and register ports of the press classifier, keeps
// its own copy of the press-tracking state and compares every result item with
// the event that the accepted poll should produce.
module bpc_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [31:0]                    in_now_ms,
  input  logic                           in_pin_level,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [1:0]                     out_press_event,
  input  logic                           cfg_we,
  input  logic [bpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bpc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                             errors,
  output int                             pending,
  output int                             polls,
  output int                             shorts,
  output int                             longs,
  output int                             doubles
);
  import bpc_pkg::*;

  // Mirrored registers
  logic        btn_enabled;
  logic [15:0] bounce_ms;
  logic [15:0] long_ms;
  logic [15:0] gap_ms;

  // Mirrored press tracking
  logic        held;
  logic        second_pending;
  logic [31:0] hold_begin_ms;
  logic [31:0] release_ms;

  // Events owed by the block, oldest first
  bpc_event_t  expected_events[$];

  // One poll through the classifier; updates the mirrored state
  function automatic bpc_event_t classify_poll(input logic [31:0] stamp, input logic level);
    logic        down;
    logic [31:0] hold;
    logic [31:0] since_release;
    down          = ~level;
    hold          = stamp - hold_begin_ms;
    since_release = stamp - release_ms;
    if (!btn_enabled) return EV_NONE;
    // press edge
    if (down && !held) begin
      held          = 1'b1;
      hold_begin_ms = stamp;
      return EV_NONE;
    end
    // release edge: bounce first, then long, then short / double
    if (!down && held) begin
      held = 1'b0;
      if (hold < {16'd0, bounce_ms}) return EV_NONE;
      if (hold >= {16'd0, long_ms}) begin
        second_pending = 1'b0;
        return EV_LONG;
      end
      if (second_pending) begin
        second_pending = 1'b0;
        return EV_DOUBLE;
      end
      second_pending = 1'b1;
      release_ms     = stamp;
      return EV_NONE;
    end
    // no second press in time: report the single short press
    if (second_pending && !down && since_release > {16'd0, gap_ms}) begin
      second_pending = 1'b0;
      return EV_SHORT;
    end
    return EV_NONE;
  endfunction

  always @(posedge clk) begin
    bpc_event_t want;
    if (!rst_n) begin
      btn_enabled    = 1'b0;
      bounce_ms      = DEBOUNCE_RST;
      long_ms        = LONG_PRESS_RST;
      gap_ms         = DOUBLE_GAP_RST;
      held           = 1'b0;
      second_pending = 1'b0;
      hold_begin_ms  = '0;
      release_ms     = '0;
      expected_events.delete();
    end else begin
      // result side: compare against the oldest owed event
      if (out_valid && !out_stall) begin
        if (expected_events.size() == 0) begin
          errors++;
          $display("%0t: unexpected result item, event %0d with nothing owed",
                   $time, out_press_event);
        end else begin
          want = expected_events.pop_front();
          if (out_press_event !== want) begin
            errors++;
            $display("%0t: press_event mismatch, expected %0d, actual %0d",
                     $time, want, out_press_event);
          end
          case (want)
            EV_SHORT:  shorts++;
            EV_LONG:   longs++;
            EV_DOUBLE: doubles++;
            default: ;
          endcase
        end
      end
      // poll side
      if (in_valid && !in_stall) begin
        expected_events.push_back(classify_poll(in_now_ms, in_pin_level));
        polls++;
      end
      // register writes; unknown indexes are dropped
      if (cfg_we) begin
        case (cfg_index)
          CFG_BUTTON_ENABLED: btn_enabled = cfg_wdata[0];
          CFG_DEBOUNCE_MS:    bounce_ms   = cfg_wdata;
          CFG_LONG_PRESS_MS:  long_ms     = cfg_wdata;
          CFG_DOUBLE_GAP_MS:  gap_ms      = cfg_wdata;
          default: ;
        endcase
      end
    end
    pending = expected_events.size();
  end

endmodule

// ===== tb/tb_button_press_classifier.sv =====
`timescale 1ns / 1ps

module tb_button_press_classifier;
  import bpc_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASES       = 12;
  localparam int PHASE_POLLS  = 60;
  localparam int QUIET_PHASES = 2;
  localparam int SETTLE       = 4;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [31:0]           in_now_ms;
  logic                  in_pin_level;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [1:0]            out_press_event;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int errors, pending, polls, shorts, longs, doubles;

  // Stimulus bookkeeping
  int          idle_pct;
  int          stall_left = 0;
  int          cycle_cnt = 0;
  int          settings;
  int unsigned cur_deb, cur_long, cur_gap;
  logic [31:0] stamp_ms;

  button_press_classifier u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_now_ms       (in_now_ms),
    .in_pin_level    (in_pin_level),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_press_event (out_press_event),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  bpc_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_now_ms       (in_now_ms),
    .in_pin_level    (in_pin_level),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_press_event (out_press_event),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .errors          (errors),
    .pending         (pending),
    .polls           (polls),
    .shorts          (shorts),
    .longs           (longs),
    .doubles         (doubles)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t: watchdog expired", $time);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result-side backpressure in random bursts
  always @(posedge clk) begin
    if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else if (stall_left == 1) begin
      stall_left <= 0;
      out_stall  <= 1'b0;
    end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(1, 15);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Present one poll and hold it until accepted
  task automatic send_poll(input logic [31:0] stamp, input logic level);
    logic stalled;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_now_ms    <= stamp;
    in_pin_level <= level;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
  endtask

  // Stop polling and wait until every owed result has come out
  task automatic drain_results;
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Leaves cfg_we high; the caller lowers it after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic program_regs(input logic en, input int unsigned deb,
                              input int unsigned lng, input int unsigned gap);
    logic [15:0] en_word;
    en_word    = 16'($urandom);
    en_word[0] = en;
    write_reg(CFG_BUTTON_ENABLED, en_word);
    write_reg(CFG_DEBOUNCE_MS, deb[15:0]);
    write_reg(CFG_LONG_PRESS_MS, lng[15:0]);
    write_reg(CFG_DOUBLE_GAP_MS, gap[15:0]);
    // unused index must change nothing
    write_reg(CFG_IDX_W'($urandom_range(CFG_DOUBLE_GAP_MS + 1, 255)), 16'($urandom));
    cfg_we   <= 1'b0;
    cur_deb  = deb;
    cur_long = lng;
    cur_gap  = gap;
    settings++;
  endtask

  // Hold durations clustered around the thresholds
  function automatic int unsigned pick_hold();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, cur_deb);
      1: return cur_deb + $urandom_range(0, 2) - 1;
      2: return (cur_long > cur_deb) ? cur_deb + $urandom_range(0, cur_long - cur_deb) : cur_deb;
      3: return cur_long + $urandom_range(0, 2) - 1;
      4: return cur_long + $urandom_range(0, 2000);
      default: return $urandom_range(0, 3000);
    endcase
  endfunction

  // Released spans clustered around the double-press gap
  function automatic int unsigned pick_pause();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, cur_gap);
      1: return cur_gap + $urandom_range(0, 2) - 1;
      2: return $urandom_range(0, 50);
      default: return cur_gap + $urandom_range(0, 3000);
    endcase
  endfunction

  // One press/release with optional held and released polls, or noise
  task automatic play_gesture;
    int unsigned hold;
    int          n;
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, 3);
      repeat (n) begin
        stamp_ms = $urandom;
        send_poll(stamp_ms, 1'($urandom_range(0, 1)));
      end
    end else begin
      hold = pick_hold();
      send_poll(stamp_ms, 1'b0);
      if ($urandom_range(0, 2) == 0) send_poll(stamp_ms + hold / 2, 1'b0);
      stamp_ms += hold;
      send_poll(stamp_ms, 1'b1);
      n = $urandom_range(0, 3);
      repeat (n) begin
        stamp_ms += pick_pause();
        send_poll(stamp_ms, 1'b1);
      end
      stamp_ms += pick_pause();
    end
  endtask

  initial begin
    int target;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_now_ms    = '0;
    in_pin_level = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_wdata    = '0;
    idle_pct     = 0;
    settings     = 1;
    cur_deb      = 32'(DEBOUNCE_RST);
    cur_long     = 32'(LONG_PRESS_RST);
    cur_gap      = 32'(DOUBLE_GAP_RST);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: button absent after reset, then reset thresholds
    send_poll(32'hFFFF_FFFF, 1'b0);
    send_poll(32'h0000_0000, 1'b1);
    drain_results;
    write_reg(CFG_BUTTON_ENABLED, 16'd1);
    cfg_we <= 1'b0;
    // short press across the 32-bit wrap, with a held poll
    stamp_ms = 32'hFFFF_FF00;
    send_poll(stamp_ms, 1'b0);
    send_poll(stamp_ms + 10, 1'b0);
    stamp_ms += 400;
    send_poll(stamp_ms, 1'b1);
    // exactly at the gap still waits, one past it reports short
    send_poll(stamp_ms + 300, 1'b1);
    stamp_ms += 301;
    send_poll(stamp_ms, 1'b1);
    // bounce
    stamp_ms += 1000;
    send_poll(stamp_ms, 1'b0);
    send_poll(stamp_ms + 49, 1'b1);
    // hold exactly at debounce, then a second short press: double
    stamp_ms += 100;
    send_poll(stamp_ms, 1'b0);
    stamp_ms += 50;
    send_poll(stamp_ms, 1'b1);
    stamp_ms += 20;
    send_poll(stamp_ms, 1'b0);
    stamp_ms += 999;
    send_poll(stamp_ms, 1'b1);
    // hold exactly at the long threshold
    stamp_ms += 500;
    send_poll(stamp_ms, 1'b0);
    stamp_ms += 1000;
    send_poll(stamp_ms, 1'b1);
    // long press cancels a waiting short press
    stamp_ms += 10;
    send_poll(stamp_ms, 1'b0);
    stamp_ms += 200;
    send_poll(stamp_ms, 1'b1);
    stamp_ms += 100;
    send_poll(stamp_ms, 1'b0);
    stamp_ms += 5000;
    send_poll(stamp_ms, 1'b1);
    stamp_ms += 1000;
    send_poll(stamp_ms, 1'b1);

    // Random phases: extreme settings and a disabled button first, then random ones
    for (int ph = 0; ph < PHASES; ph++) begin
      drain_results;
      case (ph)
        0: program_regs(1'b1, 0, 0, 0);
        1: program_regs(1'b1, 65535, 65535, 65535);
        2: program_regs(1'b1, 400, 100, 0);
        3: program_regs(1'b0, $urandom_range(0, 200), $urandom_range(0, 2500),
                        $urandom_range(0, 800));
        4: program_regs(1'b1, 0, 65535, 0);
        default: program_regs($urandom_range(0, 7) != 0, $urandom_range(0, 200),
                              $urandom_range(0, 2500), $urandom_range(0, 800));
      endcase
      case ($urandom_range(0, 2))
        0: idle_pct = 0;
        1: idle_pct = 10;
        default: idle_pct = 30;
      endcase
      if (ph >= PHASES - QUIET_PHASES) idle_pct = 0;
      target = polls + PHASE_POLLS;
      while (polls < target) play_gesture();
    end

    drain_results;
    $display("Checked %0d polls over %0d register settings with backpressure on both sides.",
             polls, settings);
    $display("Events seen: %0d short, %0d long, %0d double presses.", shorts, longs, doubles);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
